// ===== design/spjq_pkg.sv =====
`timescale 1ns / 1ps

package spjq_pkg;

    // Fixed field widths of the command and result items
    localparam int NUM_CLASSES = 6;
    localparam int CMD_W       = 2;
    localparam int CLASS_W     = 3;
    localparam int JOB_ID_W    = 16;
    localparam int STATUS_W    = 2;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Result item handed from the controller to the output register
    typedef struct packed {
        logic                any_pending;
        logic [CLASS_W-1:0]  out_class;
        logic [JOB_ID_W-1:0] out_id;
        t_status             status;
    } t_result;

endpackage

// ===== design/spjq_mem.sv =====
`timescale 1ns / 1ps

module spjq_mem import spjq_pkg::*; #(
    parameter int DEPTH  = 96,
    parameter int DATA_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/spjq_ctrl.sv =====
`timescale 1ns / 1ps

module spjq_ctrl import spjq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SW          = 16,
    parameter int AW          = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  t_cmd                i_cmd,
    input  logic [CLASS_W-1:0]  i_job_class,
    input  logic [SW-1:0]       i_job_id,
    // result side
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_result             o_res,
    // id store
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [SW-1:0]       o_wr_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  logic [SW-1:0]       i_rd_data
);

    localparam int KW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0]   DEPTH_A = AW'(QUEUE_DEPTH);
    localparam logic [CW-1:0]   DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_counts [NUM_CLASSES];
    logic [CW-1:0]         n_counts [NUM_CLASSES];
    logic [CLASS_W-1:0]    r_cls, n_cls;
    logic [SW-1:0]         r_id, n_id;
    logic [KW-1:0]         r_k, n_k;
    logic                  r_is_pop, n_is_pop;
    t_status               r_status, n_status;
    logic [JOB_ID_W-1:0]   r_rid, n_rid;
    logic [CLASS_W-1:0]    r_rcls, n_rcls;

    logic [CW-1:0]         in_cnt;
    logic [CW-1:0]         cur_cnt;
    logic                  in_cls_ok;
    logic                  any_found;
    logic [CLASS_W-1:0]    first_cls;
    logic                  any_pending;
    logic [CW:0]           kx1;
    logic [CW:0]           kx2;
    logic                  hit;
    logic [CLASS_W-1:0]    rd_cls;
    logic [KW-1:0]         rd_k;
    logic [CLASS_W-1:0]    wr_cls;
    logic [KW-1:0]         wr_k;

    function automatic logic [AW-1:0] slot_addr(input logic [CLASS_W-1:0] cls,
                                                 input logic [KW-1:0] k);
        logic [AW-1:0] base;
        base = AW'(cls) * DEPTH_A;
        return base + AW'(k);
    endfunction

    // Count lookups, head search and pending flag over the six classes
    always_comb begin
        in_cnt      = '0;
        cur_cnt     = '0;
        any_found   = 1'b0;
        first_cls   = '0;
        any_pending = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (i_job_class == CLASS_W'(c)) begin
                in_cnt = r_counts[c];
            end
            if (r_cls == CLASS_W'(c)) begin
                cur_cnt = r_counts[c];
            end
            if (r_counts[c] != '0) begin
                any_found   = 1'b1;
                first_cls   = CLASS_W'(c);
                any_pending = 1'b1;
            end
        end
    end

    assign in_cls_ok = (i_job_class < CLASS_W'(NUM_CLASSES));
    assign kx1       = (CW+1)'(r_k) + (CW+1)'(1);
    assign kx2       = (CW+1)'(r_k) + (CW+1)'(2);
    assign hit       = r_is_pop || (i_rd_data == r_id);

    // Next-state logic and id store access
    always_comb begin
        n_state  = r_state;
        n_counts = r_counts;
        n_cls    = r_cls;
        n_id     = r_id;
        n_k      = r_k;
        n_is_pop = r_is_pop;
        n_status = r_status;
        n_rid    = r_rid;
        n_rcls   = r_rcls;
        o_wr_en  = 1'b0;
        wr_cls   = r_cls;
        wr_k     = r_k;
        o_wr_data = i_rd_data;
        o_rd_en  = 1'b0;
        rd_cls   = r_cls;
        rd_k     = KW'(kx1);

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_status = ST_OK;
                    n_rid    = '0;
                    n_rcls   = '0;
                    n_state  = S_RESULT;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (in_cls_ok && (in_cnt < DEPTH_C)) begin
                                o_wr_en   = 1'b1;
                                wr_cls    = i_job_class;
                                wr_k      = KW'(in_cnt);
                                o_wr_data = i_job_id;
                                for (int c = 0; c < NUM_CLASSES; c++) begin
                                    if (i_job_class == CLASS_W'(c)) begin
                                        n_counts[c] = r_counts[c] + CW'(1);
                                    end
                                end
                                n_rid  = JOB_ID_W'(i_job_id);
                                n_rcls = i_job_class;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_POP: begin
                            if (any_found) begin
                                o_rd_en  = 1'b1;
                                rd_cls   = first_cls;
                                rd_k     = '0;
                                n_cls    = first_cls;
                                n_k      = '0;
                                n_is_pop = 1'b1;
                                n_state  = S_SCAN;
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                        CMD_REMOVE: begin
                            if (in_cls_ok && (in_cnt != '0)) begin
                                o_rd_en  = 1'b1;
                                rd_cls   = i_job_class;
                                rd_k     = '0;
                                n_cls    = i_job_class;
                                n_id     = i_job_id;
                                n_k      = '0;
                                n_is_pop = 1'b0;
                                n_state  = S_SCAN;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            // Compare slot k; prefetch slot k+1 for the next compare or the shift
            S_SCAN: begin
                o_rd_en = (kx1 < (CW+1)'(cur_cnt));
                rd_k    = KW'(kx1);
                if (hit) begin
                    n_status = ST_OK;
                    n_rid    = JOB_ID_W'(i_rd_data);
                    n_rcls   = r_cls;
                    if (kx1 < (CW+1)'(cur_cnt)) begin
                        n_state = S_SHIFT;
                    end else begin
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                            if (r_cls == CLASS_W'(c)) begin
                                n_counts[c] = r_counts[c] - CW'(1);
                            end
                        end
                        n_state = S_RESULT;
                    end
                end else if (kx1 < (CW+1)'(cur_cnt)) begin
                    n_k = KW'(kx1);
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_rid    = '0;
                    n_rcls   = '0;
                    n_state  = S_RESULT;
                end
            end

            // Move slot k+1 into slot k, one entry a cycle, and close the gap
            S_SHIFT: begin
                o_wr_en   = 1'b1;
                wr_k      = r_k;
                o_wr_data = i_rd_data;
                o_rd_en   = (kx2 < (CW+1)'(cur_cnt));
                rd_k      = KW'(kx2);
                if (kx2 < (CW+1)'(cur_cnt)) begin
                    n_k = KW'(kx1);
                end else begin
                    for (int c = 0; c < NUM_CLASSES; c++) begin
                        if (r_cls == CLASS_W'(c)) begin
                            n_counts[c] = r_counts[c] - CW'(1);
                        end
                    end
                    n_state = S_RESULT;
                end
            end

            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_wr_addr = slot_addr(wr_cls, wr_k);
    assign o_rd_addr = slot_addr(rd_cls, rd_k);

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res.status      = r_status;
    assign o_res.out_id      = r_rid;
    assign o_res.out_class   = r_rcls;
    assign o_res.any_pending = any_pending;

    // Hold state, counts and the pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_counts[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_counts <= n_counts;
        end
        r_cls    <= n_cls;
        r_id     <= n_id;
        r_k      <= n_k;
        r_is_pop <= n_is_pop;
        r_status <= n_status;
        r_rid    <= n_rid;
        r_rcls   <= n_rcls;
    end

endmodule

// ===== design/strict_priority_job_queues_top.sv =====
`timescale 1ns / 1ps

// Strict-priority job queues: six FIFO queues of job ids, one per class.
// Slave stream carries commands (push, pop, remove); master stream carries
// one result item per command: status, job id, class and a pending flag.
// Classes are served in order load, transform, thumbnail, model, save, copy.
// Push, an empty pop, a remove on an empty or unknown class and a nop command
// go from accept straight to the result state without reading the id store. Pop
// and remove read the class queue from the id store one slot a cycle to find the
// entry, then move the later entries one slot toward the head, one a cycle; a
// remove that matches nothing scans all count slots. The single id store port
// pair sets that pace. One command is in work at a time; the next is accepted
// once the result has moved into the output register. Reset clears the six
// queue counts, so all queues read empty at once; the id store itself needs no
// clearing. When the receiver stalls, the result waits in the output register,
// one more command is worked, and its result holds the controller until the
// register drains.
module strict_priority_job_queues_top import spjq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [1:0] cmd, [4:2] job_class, [20:5] job_id, [23:21] zero
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [1:0] status, [17:2] out_id, [20:18] out_class, [21] any_pending, [23:22] zero
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    localparam int SW        = (ID_BITS < JOB_ID_W) ? ID_BITS : JOB_ID_W;
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] rd_data;

    logic          r_m_valid;
    t_result       r_m_res;

    spjq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SW          (SW),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_s_axis_tvalid),
        .o_cmd_ready (o_s_axis_tready),
        .i_cmd       (t_cmd'(i_s_axis_tdata[1:0])),
        .i_job_class (i_s_axis_tdata[4:2]),
        .i_job_id    (i_s_axis_tdata[5 +: SW]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    spjq_mem #(
        .DEPTH  (MEM_DEPTH),
        .DATA_W (SW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: load a result when empty or draining
    assign res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_m_res.any_pending, r_m_res.out_class,
                              r_m_res.out_id, r_m_res.status};

endmodule
